// ----- rtl/pph_pkg.sv -----
// Shared constants, codes and types of the per-pixel amplitude histogram.
package pph_pkg;

  // Detector geometry and histogram depth.
  localparam int QUADS              = 4;
  localparam int SECTIONS           = 8;
  localparam int PIXELS_PER_SECTION = 256;
  localparam int BINS               = 128;

  localparam int TOTAL_PIXELS = QUADS * SECTIONS * PIXELS_PER_SECTION;
  localparam int STORE_SIZE   = TOTAL_PIXELS * BINS;

  localparam int PIX_W    = (TOTAL_PIXELS > 1) ? $clog2(TOTAL_PIXELS) : 1;
  localparam int PCNT_W   = $clog2(TOTAL_PIXELS + 1);
  localparam int BIN_W    = $clog2(BINS);
  localparam int ADDR_W   = $clog2(STORE_SIZE);
  localparam int SECPIX_W = (PIXELS_PER_SECTION > 1) ? $clog2(PIXELS_PER_SECTION) : 1;
  localparam int SECT_W   = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int QUAD_W   = (QUADS > 1) ? $clog2(QUADS) : 1;

  localparam int CNT_W = 32;

  // Stream payload widths.
  localparam int IN_DATA_W  = 40;  // amplitude, read_pixel, read_bin, padding
  localparam int IN_USER_W  = 2;   // kind, frame_start
  localparam int OUT_DATA_W = 56;  // counter_value, bin_index, pixel_index, padding
  localparam int OUT_USER_W = 2;   // counted, overflow

  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_MIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_SCALE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROI_MASK   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_EVENTS = 3'd4;

  // Configuration reset values.
  localparam logic [7:0]  BIN_COUNT_RST  = 8'd100;
  localparam logic [15:0] AMP_MIN_RST    = 16'd0;
  localparam logic [23:0] BIN_SCALE_RST  = 24'd6554;
  localparam logic [31:0] ROI_MASK_RST   = 32'hFFFF_FFFF;
  localparam logic [31:0] MAX_EVENTS_RST = 32'h8000_0000;

  // Item kinds.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // What an item does once it is classified at the input.
  typedef enum logic [2:0] {
    OP_NONE,      // sample outside an accepted frame
    OP_PAST_END,  // sample beyond the last pixel of the frame
    OP_SKIP,      // sample in a masked-off section
    OP_BIN,       // sample that updates a counter
    OP_READ,      // counter read
    OP_READ_OOR   // counter read outside the store
  } op_t;

endpackage

// ----- rtl/pph_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module pph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when both ports hit one entry.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/per_pixel_amplitude_histogram.sv -----
// Per-pixel amplitude histogram: frame pixel tracking, binning and counter update.
//
//   channel | direction | handshake              | payload
//   in_     | slave     | in_tvalid / in_tready   | in_tdata, in_tuser
//   out_    | master    | out_tvalid / out_tready | out_tdata, out_tuser
//   cfg_    | slave     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One item per cycle while the output is not stalled and no clearing pass runs.
// Stages: classify and subtract, multiply, clamp and RAM read, update and write back.
// The counter write back in the last stage is forwarded to the next item's read.
// After reset a clearing pass zeroes the counter RAM, one entry per cycle, over all
// STORE_SIZE (1048576) entries, during which in_tready stays low.
// A stalled output freezes the whole pipeline, RAM read port included.
module per_pixel_amplitude_histogram
  import pph_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input items
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // amplitude[15:0], read_pixel[28:16], read_bin[35:29]
  input  logic [IN_USER_W-1:0]  in_tuser,   // kind[0], frame_start[1]
  // results
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // counter_value[31:0], bin_index[38:32],
                                            // pixel_index[51:39]
  output logic [OUT_USER_W-1:0] out_tuser,  // counted[0], overflow[1]
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]           cfg_data
);

  // configuration registers
  logic [7:0]  bin_count_r;
  logic [15:0] amp_min_r;
  logic [23:0] bin_scale_r;
  logic [31:0] roi_mask_r;
  logic [31:0] max_events_r;

  // frame tracking
  logic [PCNT_W-1:0]   pcnt_r, pcnt_nxt, p_cur;
  logic [SECPIX_W-1:0] secpix_r, secpix_nxt, secpix_cur;
  logic [SECT_W-1:0]   sect_r, sect_nxt, sect_cur;
  logic [QUAD_W-1:0]   quad_r, quad_nxt, quad_cur;
  logic [31:0]         fcnt_r, fcnt_nxt;
  logic                factive_r, factive_nxt, active;
  logic [4:0]          mask_idx;

  // clearing pass
  logic              clr_active_r, clr_active_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;

  // input fields
  logic               in_kind, in_fstart;
  logic [15:0]        in_amp;
  logic [12:0]        in_rpix;
  logic [6:0]         in_rbin;
  logic               in_xfer, adv;

  // stage 0 decode
  op_t                s0_op;
  logic [PIX_W-1:0]   s0_pix;
  logic [BIN_W-1:0]   s0_bin;
  logic signed [16:0] s0_diff;

  // pipeline
  logic               s1_valid_r, s2_valid_r, s3_valid_r;
  op_t                s1_op_r, s2_op_r, s3_op_r;
  logic [PIX_W-1:0]   s1_pix_r, s2_pix_r, s3_pix_r;
  logic [BIN_W-1:0]   s1_bin_r, s2_bin_r, s3_bin_r;
  logic signed [16:0] s1_diff_r;
  logic signed [41:0] s2_prod_r;
  logic [ADDR_W-1:0]  s3_addr_r;

  // stage 2 clamp and address
  logic [31:0]        nb;
  logic [BIN_W-1:0]   nb_m1;
  logic [25:0]        idx;
  logic [BIN_W-1:0]   s2_bin_sel;
  logic [ADDR_W-1:0]  s2_addr;

  // stage 3 update
  logic [CNT_W-1:0]   rd_data, old_val, new_val, s3_cval;
  logic               s3_wr, s3_counted, s3_ovf;
  logic [BIN_W-1:0]   s3_bin_out;
  logic               fw_valid_r;
  logic [ADDR_W-1:0]  fw_addr_r;
  logic [CNT_W-1:0]   fw_data_r;

  // RAM ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CNT_W-1:0]  ram_wdata;

  // output register
  logic              out_valid_r;
  logic [CNT_W-1:0]  out_cval_r;
  logic [6:0]        out_bin_r;
  logic [12:0]       out_pix_r;
  logic              out_counted_r, out_ovf_r;

  assign in_kind   = in_tuser[0];
  assign in_fstart = in_tuser[1];
  assign in_amp    = in_tdata[15:0];
  assign in_rpix   = in_tdata[28:16];
  assign in_rbin   = in_tdata[35:29];

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !clr_active_r && adv;
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r  <= BIN_COUNT_RST;
      amp_min_r    <= AMP_MIN_RST;
      bin_scale_r  <= BIN_SCALE_RST;
      roi_mask_r   <= ROI_MASK_RST;
      max_events_r <= MAX_EVENTS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BIN_COUNT:  bin_count_r  <= cfg_data[7:0];
        REG_AMP_MIN:    amp_min_r    <= cfg_data[15:0];
        REG_BIN_SCALE:  bin_scale_r  <= cfg_data[23:0];
        REG_ROI_MASK:   roi_mask_r   <= cfg_data;
        REG_MAX_EVENTS: max_events_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 0: frame and pixel tracking, item classification
  assign mask_idx = 5'((32'(quad_cur) << 3) + 32'(sect_cur));
  assign s0_diff  = $signed({in_amp[15], in_amp}) - $signed({amp_min_r[15], amp_min_r});

  always_comb begin
    p_cur       = pcnt_r;
    secpix_cur  = secpix_r;
    sect_cur    = sect_r;
    quad_cur    = quad_r;
    active      = factive_r;
    fcnt_nxt    = fcnt_r;
    factive_nxt = factive_r;
    s0_op       = OP_NONE;
    s0_pix      = '0;
    s0_bin      = '0;
    if (in_kind == KIND_READ) begin
      s0_pix = PIX_W'(in_rpix);
      s0_bin = BIN_W'(in_rbin);
      if (32'(in_rpix) < TOTAL_PIXELS && 32'(in_rbin) < BINS) begin
        s0_op = OP_READ;
      end else begin
        s0_op = OP_READ_OOR;
      end
    end else if (in_fstart) begin
      p_cur      = '0;
      secpix_cur = '0;
      sect_cur   = '0;
      quad_cur   = '0;
      if (fcnt_r < max_events_r) begin
        active = 1'b1;
        if (fcnt_r != '1) begin
          fcnt_nxt = fcnt_r + 32'd1;
        end
      end else begin
        active = 1'b0;
      end
      factive_nxt = active;
    end

    pcnt_nxt   = p_cur;
    secpix_nxt = secpix_cur;
    sect_nxt   = sect_cur;
    quad_nxt   = quad_cur;
    if (in_kind == KIND_SAMPLE && active) begin
      if (32'(p_cur) >= TOTAL_PIXELS) begin
        s0_op = OP_PAST_END;
      end else begin
        s0_pix   = PIX_W'(p_cur);
        pcnt_nxt = p_cur + 1'b1;
        if (32'(secpix_cur) == PIXELS_PER_SECTION - 1) begin
          secpix_nxt = '0;
          if (32'(sect_cur) == SECTIONS - 1) begin
            sect_nxt = '0;
            quad_nxt = quad_cur + 1'b1;
          end else begin
            sect_nxt = sect_cur + 1'b1;
          end
        end else begin
          secpix_nxt = secpix_cur + 1'b1;
        end
        s0_op = roi_mask_r[mask_idx] ? OP_BIN : OP_SKIP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r    <= '0;
      secpix_r  <= '0;
      sect_r    <= '0;
      quad_r    <= '0;
      fcnt_r    <= '0;
      factive_r <= 1'b0;
    end else if (in_xfer) begin
      pcnt_r    <= pcnt_nxt;
      secpix_r  <= secpix_nxt;
      sect_r    <= sect_nxt;
      quad_r    <= quad_nxt;
      fcnt_r    <= fcnt_nxt;
      factive_r <= factive_nxt;
    end
  end

  // clearing pass after reset
  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    if (clr_active_r) begin
      if (32'(clr_addr_r) == STORE_SIZE - 1) begin
        clr_active_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_xfer;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  // stage 2: clamp bin, form address
  always_comb begin
    if (bin_count_r == 8'd0) begin
      nb = 32'd1;
    end else if (32'(bin_count_r) > BINS) begin
      nb = 32'(BINS);
    end else begin
      nb = 32'(bin_count_r);
    end
    nb_m1 = BIN_W'(nb - 32'd1);
    idx   = s2_prod_r[41:16];
    if (s2_op_r != OP_BIN) begin
      s2_bin_sel = s2_bin_r;
    end else if (s2_prod_r[41]) begin
      s2_bin_sel = '0;
    end else if (32'(idx) > 32'(nb_m1)) begin
      s2_bin_sel = nb_m1;
    end else begin
      s2_bin_sel = BIN_W'(idx);
    end
    if (s2_op_r == OP_READ_OOR) begin
      s2_addr = '0;
    end else begin
      s2_addr = ADDR_W'(64'(s2_pix_r) * 64'(BINS) + 64'(s2_bin_sel));
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r   <= s0_op;
      s1_pix_r  <= s0_pix;
      s1_bin_r  <= s0_bin;
      s1_diff_r <= s0_diff;
      s2_op_r   <= s1_op_r;
      s2_pix_r  <= s1_pix_r;
      s2_bin_r  <= s1_bin_r;
      s2_prod_r <= $signed({1'b0, bin_scale_r}) * s1_diff_r;
      s3_op_r   <= s2_op_r;
      s3_pix_r  <= s2_pix_r;
      s3_bin_r  <= s2_bin_sel;
      s3_addr_r <= s2_addr;
    end
  end

  // stage 3: read-modify-write with forwarding of the previous write
  assign old_val = (fw_valid_r && fw_addr_r == s3_addr_r) ? fw_data_r : rd_data;
  assign new_val = old_val + 32'd1;

  always_comb begin
    s3_wr      = 1'b0;
    s3_counted = 1'b0;
    s3_ovf     = 1'b0;
    s3_cval    = '0;
    s3_bin_out = '0;
    unique case (s3_op_r)
      OP_BIN: begin
        s3_bin_out = s3_bin_r;
        if (old_val == '1) begin
          s3_ovf  = 1'b1;
          s3_cval = old_val;
        end else begin
          s3_wr      = 1'b1;
          s3_counted = 1'b1;
          s3_cval    = new_val;
        end
      end
      OP_READ: begin
        s3_bin_out = s3_bin_r;
        s3_cval    = old_val;
      end
      OP_READ_OOR: s3_bin_out = s3_bin_r;
      OP_PAST_END: s3_ovf = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_valid_r <= 1'b0;
    end else if (adv) begin
      fw_valid_r <= s3_valid_r && s3_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fw_addr_r <= s3_addr_r;
      fw_data_r <= new_val;
    end
  end

  assign ram_we    = clr_active_r || (adv && s3_valid_r && s3_wr);
  assign ram_waddr = clr_active_r ? clr_addr_r : s3_addr_r;
  assign ram_wdata = clr_active_r ? '0 : new_val;

  pph_ram #(
    .WIDTH (CNT_W),
    .DEPTH (STORE_SIZE)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (adv),
    .raddr (s2_addr),
    .rdata (rd_data)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_cval_r    <= s3_cval;
      out_bin_r     <= 7'(s3_bin_out);
      out_pix_r     <= (s3_op_r == OP_NONE || s3_op_r == OP_PAST_END) ? 13'd0 : 13'(s3_pix_r);
      out_counted_r <= s3_counted;
      out_ovf_r     <= s3_ovf;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_pix_r, out_bin_r, out_cval_r};
  assign out_tuser  = {out_ovf_r, out_counted_r};

endmodule

// ----- tb/per_pixel_amplitude_histogram_test.sv -----
// Self-checking stream testbench for the per-pixel amplitude histogram block.
module per_pixel_amplitude_histogram_test;
  import pph_pkg::*;

  localparam int HOLD_AT     = 120;             // accepted items before the long output stall
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 3 * STORE_SIZE;  // covers the counter RAM clear after reset
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 10;

  typedef struct packed {
    logic              kind;
    logic              frame_start;
    logic [15:0]       amplitude;
    logic [PIX_W-1:0]  read_pixel;
    logic [BIN_W-1:0]  read_bin;
  } pix_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]  counter_value;
    logic [BIN_W-1:0]  bin_index;
    logic [PIX_W-1:0]  pixel_index;
    logic              counted;
    logic              overflow;
  } bin_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // amplitude, read_pixel, read_bin
  logic [IN_USER_W-1:0]  in_tuser = '0;   // kind, frame_start
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // counter_value, bin_index, pixel_index
  logic [OUT_USER_W-1:0] out_tuser;       // counted, overflow
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [31:0]           cfg_data = '0;

  per_pixel_amplitude_histogram dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state and register copies.
  int unsigned        hist_store [int unsigned];
  int unsigned        touched_addr [$];
  int unsigned        pix_cnt = 0;
  int unsigned        frames_taken = 0;
  bit                 frame_open = 1'b0;
  logic [7:0]         bins_cfg = BIN_COUNT_RST;
  logic signed [15:0] amin_cfg = AMP_MIN_RST;
  logic [23:0]        scale_cfg = BIN_SCALE_RST;
  logic [31:0]        roi_cfg = ROI_MASK_RST;
  logic [31:0]        max_ev_cfg = MAX_EVENTS_RST;

  pix_item_t   pixel_stream_q [$];
  bin_result_t expected_readout_q [$];
  pix_item_t   cur_item;

  int fail_count = 0;
  int items_in = 0;
  int n_results = 0, n_reads = 0, n_counted = 0, n_skipped = 0;
  int n_past_end = 0, n_outside = 0, n_cfg = 0;
  int burst_left = 0, gap_left = 0;
  int hold_left = 0, mode_left = 0;
  bit hold_used = 1'b0, choppy = 1'b0;
  int stuck_cycles = 0;

  function automatic int unsigned bins_in_use();
    if (bins_cfg == 8'd0) return 1;
    if (bins_cfg > BINS) return BINS;
    return bins_cfg;
  endfunction

  function automatic logic [BIN_W-1:0] amp_to_bin_idx(logic signed [15:0] amp);
    longint            prod;
    longint unsigned   idx;
    prod = longint'(scale_cfg) * (longint'(amp) - longint'(amin_cfg));
    if (prod < 0) return '0;
    idx = longint'(prod >>> 16);
    if (idx > bins_in_use() - 1) idx = bins_in_use() - 1;
    return idx[BIN_W-1:0];
  endfunction

  // Applies one accepted item to the model histogram and returns the readout it causes.
  function automatic bin_result_t histogram_update(pix_item_t it);
    bin_result_t      r;
    int unsigned      sect, quad, addr;
    logic [BIN_W-1:0] b;
    r = '0;
    if (it.kind == KIND_READ) begin
      n_reads++;
      addr = it.read_pixel * BINS + it.read_bin;
      r.counter_value = hist_store.exists(addr) ? hist_store[addr] : 0;
      r.pixel_index = it.read_pixel;
      r.bin_index = it.read_bin;
      return r;
    end
    if (it.frame_start) begin
      pix_cnt = 0;
      frame_open = (frames_taken < max_ev_cfg);
      if (frame_open && frames_taken != 32'hFFFF_FFFF) frames_taken++;
    end
    if (!frame_open) begin
      n_outside++;
    end else if (pix_cnt >= TOTAL_PIXELS) begin
      r.overflow = 1'b1;
      n_past_end++;
    end else begin
      sect = (pix_cnt / PIXELS_PER_SECTION) % SECTIONS;
      quad = pix_cnt / (PIXELS_PER_SECTION * SECTIONS);
      r.pixel_index = pix_cnt[PIX_W-1:0];
      addr = pix_cnt * BINS;
      pix_cnt++;
      if (!roi_cfg[(quad * 8 + sect) & 31]) begin
        n_skipped++;
      end else begin
        b = amp_to_bin_idx(it.amplitude);
        addr += b;
        if (!hist_store.exists(addr)) begin
          hist_store[addr] = 0;
          touched_addr.push_back(addr);
        end
        if (hist_store[addr] == 32'hFFFF_FFFF) begin
          r.overflow = 1'b1;
        end else begin
          hist_store[addr]++;
          r.counted = 1'b1;
          n_counted++;
        end
        r.counter_value = hist_store[addr];
        r.bin_index = b;
      end
    end
    return r;
  endfunction

  // Sender: bursts of random length with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_readout_q.push_back(histogram_update(cur_item));
        items_in <= items_in + 1;
      end
      if (in_tvalid && !in_tready) begin
        // hold the offered transfer
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pixel_stream_q.size() > 0) begin
        cur_item = pixel_stream_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= IN_DATA_W'({cur_item.read_bin, cur_item.read_pixel, cur_item.amplitude});
        in_tuser <= {cur_item.frame_start, cur_item.kind};
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 48);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: alternates free-running and choppy stretches, plus one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!hold_used && items_in >= HOLD_AT) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        choppy <= ~choppy;
        mode_left <= $urandom_range(20, 120);
      end else begin
        mode_left <= mode_left - 1;
      end
      out_tready <= choppy ? ($urandom_range(0, 2) != 0) : 1'b1;
    end
  end

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    bin_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (expected_readout_q.size() == 0) begin
        $error("unexpected result transfer: tdata %h tuser %h", out_tdata, out_tuser);
        fail_count++;
      end else begin
        want = expected_readout_q.pop_front();
        check_field("counter_value", want.counter_value, out_tdata[31:0]);
        check_field("bin_index", want.bin_index, out_tdata[38:32]);
        check_field("pixel_index", want.pixel_index, out_tdata[51:39]);
        check_field("counted", want.counted, out_tuser[0]);
        check_field("overflow", want.overflow, out_tuser[1]);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("per_pixel_amplitude_histogram test failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    case (idx)
      REG_BIN_COUNT:  bins_cfg = val[7:0];
      REG_AMP_MIN:    amin_cfg = val[15:0];
      REG_BIN_SCALE:  scale_cfg = val[23:0];
      REG_ROI_MASK:   roi_cfg = val;
      REG_MAX_EVENTS: max_ev_cfg = val;
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic set_config(logic [7:0] nb, logic [15:0] amin, logic [23:0] scale,
                            logic [31:0] roi, logic [31:0] mev);
    write_reg(REG_BIN_COUNT, 32'(nb));
    write_reg(REG_AMP_MIN, 32'(amin));
    write_reg(REG_BIN_SCALE, 32'(scale));
    write_reg(REG_ROI_MASK, roi);
    write_reg(REG_MAX_EVENTS, mev);
  endtask

  // Blocks until the sender is drained and every readout has come back.
  task automatic wait_idle();
    while (pixel_stream_q.size() != 0 || in_tvalid || expected_readout_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_item(logic kind, logic fs, logic [15:0] amp,
                           logic [PIX_W-1:0] rp, logic [BIN_W-1:0] rb);
    pix_item_t it;
    it.kind = kind;
    it.frame_start = fs;
    it.amplitude = amp;
    it.read_pixel = rp;
    it.read_bin = rb;
    pixel_stream_q.push_back(it);
  endtask

  task automatic push_sample(logic fs, logic [15:0] amp);
    push_item(KIND_SAMPLE, fs, amp, PIX_W'($urandom), BIN_W'($urandom));
  endtask

  task automatic push_read(logic [PIX_W-1:0] rp, logic [BIN_W-1:0] rb);
    push_item(KIND_READ, 1'($urandom), 16'($urandom), rp, rb);
  endtask

  // Amplitudes mostly land in the configured bin span so every bin gets traffic.
  function automatic logic [15:0] pick_amp();
    int unsigned span;
    int          lo, hi;
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    span = (scale_cfg == 0) ? 2000 : (bins_in_use() * 65536) / scale_cfg;
    if (span > 70000) span = 70000;
    lo = int'(amin_cfg) - 40;
    hi = int'(amin_cfg) + int'(span) + 40;
    if (lo < -32768) lo = -32768;
    if (hi > 32767) hi = 32767;
    return 16'(lo + int'($urandom_range(hi - lo, 0)));
  endfunction

  task automatic push_random_read();
    int unsigned a;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4 && touched_addr.size() > 0) begin
      a = touched_addr[$urandom_range(touched_addr.size() - 1, 0)];
      push_read(PIX_W'(a / BINS), BIN_W'(a % BINS));
    end else if (sel < 8) begin
      push_read(PIX_W'($urandom_range(0, 63)), BIN_W'($urandom_range(bins_in_use() - 1, 0)));
    end else begin
      push_read(PIX_W'($urandom), BIN_W'($urandom));
    end
  endtask

  // Short frames with reads mixed in; now and then a frame with no start marker,
  // which just continues the previous one.
  task automatic push_random_frames(int n);
    int left;
    int len;
    bit open_frame;
    left = n;
    while (left > 0) begin
      len = $urandom_range(1, 12);
      if (len > left) len = left;
      open_frame = ($urandom_range(0, 9) != 0);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 7) == 0) push_random_read();
        push_sample(open_frame && i == 0, pick_amp());
      end
      left -= len;
    end
  endtask

  task automatic random_config();
    logic [7:0]  nb;
    logic [23:0] scale;
    logic [31:0] roi, mev;
    nb = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 1) == 1) nb = 8'($urandom_range(1, 128));
    scale = ($urandom_range(0, 4) == 0) ? 24'($urandom)
                                        : 24'((32'(nb) * 65536) / $urandom_range(50, 30000));
    roi = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : $urandom;
    mev = ($urandom_range(0, 3) == 0) ? frames_taken + $urandom_range(0, 3) : 32'hFFFF_FFFF;
    set_config(nb, 16'($urandom), scale, roi, mev);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset register values: reads of an empty store, samples before
    // any frame, bin edges and clamping, frame restart.
    push_read('0, '0);
    push_read('1, '1);
    push_sample(1'b0, 16'd100);
    push_sample(1'b1, 16'd0);
    push_sample(1'b0, 16'h7FFF);
    push_sample(1'b0, 16'h8000);
    push_sample(1'b0, 16'd500);
    push_sample(1'b1, 16'd500);
    push_sample(1'b0, 16'h7FFF);
    push_read(PIX_W'(1), BIN_W'(99));
    push_read(PIX_W'(3), BIN_W'(50));
    push_read('0, '0);
    wait_idle();

    // Masked-off first section, then a refused frame.
    write_reg(REG_ROI_MASK, 32'hFFFF_FFFE);
    push_sample(1'b1, 16'd200);
    push_sample(1'b0, 16'd300);
    wait_idle();
    write_reg(REG_MAX_EVENTS, frames_taken);
    push_sample(1'b1, 16'd0);
    push_sample(1'b0, 16'd0);
    push_read('0, '0);
    wait_idle();

    // A frame that runs across the first section edge into a masked-off section;
    // the long output hold-off lands inside it.
    set_config(8'd128, -16'sd1000, 24'd2097, 32'hFFFF_FFFD, 32'hFFFF_FFFF);
    push_sample(1'b1, pick_amp());
    for (int i = 0; i < PIXELS_PER_SECTION + 3; i++) push_sample(1'b0, pick_amp());
    wait_idle();

    // Register extremes.
    set_config(8'd0, 16'h8000, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_random_frames(PHASE_ITEMS);
    wait_idle();
    set_config(8'd255, 16'h8000, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_random_frames(PHASE_ITEMS);
    wait_idle();
    set_config(8'd128, 16'h7FFF, 24'd1, 32'h0000_0000, 32'hFFFF_FFFF);
    push_random_frames(PHASE_ITEMS);
    wait_idle();
    set_config(8'd1, 16'h0000, 24'd0, 32'hFFFF_FFFF, 32'h0000_0000);
    push_random_frames(PHASE_ITEMS);
    wait_idle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      random_config();
      push_random_frames(PHASE_ITEMS);
      for (int k = 0; k < 6; k++) push_random_read();
      wait_idle();
    end

    repeat (8) @(posedge clk);
    $display("covered %0d items: %0d reads, %0d binned, %0d skipped,", items_in, n_reads,
             n_counted, n_skipped);
    $display("%0d past frame end, %0d outside frames, %0d results checked, %0d register writes",
             n_past_end, n_outside, n_results, n_cfg);
    if (fail_count == 0) begin
      $display("per_pixel_amplitude_histogram test passed");
    end else begin
      $display("per_pixel_amplitude_histogram test failed");
    end
    $finish;
  end

endmodule
